### rtl/core/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

### rtl/core/abhsf_pkg.sv
// Shared types and constants for the treble shelf filter.
// Depends on nothing.
`timescale 1ns / 1ps
package abhsf_pkg;
	localparam int SampleBits = 24;
	localparam int AccBits = 32;
	localparam int CoefBits = 18;
	localparam int CoefFrac = 15;
	localparam int UnitFrac = 16;
	localparam int CrossShift = 8;
	localparam logic [16:0] Unity = 17'd65536;
	localparam logic [2:0] NumRegs = 3'd6;

	typedef enum logic [2:0] {
		REG_HI = 3'd0, REG_TRI = 3'd1, REG_AIR = 3'd2,
		REG_DAMP = 3'd3, REG_GAIN = 3'd4, REG_WET = 3'd5
	} reg_idx_t;

	// Request to the serial multiplier.
	typedef struct packed {
		logic        start;
		logic [5:0]  shift;
	} mul_req_t;
endpackage

### rtl/core/abhsf_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, rounded scale-down.
// Depends on abhsf_pkg.
`timescale 1ns / 1ps
module abhsf_mul #(
	parameter int ABits = 48,
	parameter int BBits = 18
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  abhsf_pkg::mul_req_t        req,
	input  logic signed [ABits-1:0]    a,
	input  logic signed [BBits-1:0]    b,
	output logic                       done,
	output logic signed [ABits+BBits-1:0] prod
);
	localparam int PB = ABits + BBits;
	localparam int CW = $clog2(BBits + 1);

	logic signed [PB-1:0] acc_q, mcand_q;
	logic [BBits-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [5:0] shift_q;
	logic signed [PB-1:0] rnd;

	// One multiplier bit per cycle; the top bit carries negative weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(BBits - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= PB'(a);
			mplier_q <= b;
			shift_q <= req.shift;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= (cnt_q == CW'(BBits - 1)) ? acc_q - mcand_q : acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// Round half up, then arithmetic shift.
	always_comb begin
		rnd = (shift_q == 6'd0) ? '0 : (PB'(1) <<< (shift_q - 6'd1));
		prod = (acc_q + rnd) >>> shift_q;
	end
endmodule

### rtl/core/air_band_high_shelf_filter.sv
// Treble shelf filter, top level: config registers, state, sequencer.
// Depends on abhsf_pkg, abhsf_mul and assert_macros.svh.
//
// Usage: one signed sample enters per beat on s_axis (tdata), one
// processed sample leaves per beat on m_axis. Registers are to be written
// by the user on the cfg channel (cfg_index, cfg_data) only while the
// block is idle; the block itself does not enforce this.
// Each sample runs through a sequence of 13 products on a shared serial
// multiplier that retires one coefficient bit per cycle. Each product
// has a load state, the multiplier's bit steps and a write-back when the
// multiplier is done; three accumulator updates and an output step come
// on top. One sample is processed at a time; s_axis_tready is high only
// when the sequencer is idle and the output register is empty, so the
// next input beat is taken only after the previous result has left.
// The result waits in the output register while m_axis_tready is low,
// and no new input is taken while it waits.
// Reset clears all filter state, the phase counters and loads the
// default register values (damping 40960, gain and wet at unity).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module air_band_high_shelf_filter #(
	parameter int SAMPLE_BITS = abhsf_pkg::SampleBits,
	parameter int ACC_BITS = abhsf_pkg::AccBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_in
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // sample_out
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [17:0] cfg_data
);
	localparam int W = ACC_BITS + 16;
	localparam int TW = ((SAMPLE_BITS+7)/8)*8;
	localparam int PB = W + 18;
	localparam logic signed [W-1:0] AMAX = W'((64'sd1 <<< (ACC_BITS-1)) - 1);
	localparam logic signed [W-1:0] AMIN = -W'(64'sd1 <<< (ACC_BITS-1));
	localparam logic signed [W-1:0] SMAX = W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [W-1:0] SMIN = -W'(64'sd1 <<< (SAMPLE_BITS-1));

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_PRE = 5'b00010, ST_LOAD = 5'b00100,
		ST_MUL = 5'b01000, ST_OUT = 5'b10000
	} state_t;

	// Configuration registers.
	logic signed [17:0] hi_q, tri_c_q, air_q;
	logic [15:0] damp_q;
	logic [16:0] gain_q, wet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0; tri_c_q <= '0; air_q <= '0;
			damp_q <= 16'd40960; gain_q <= abhsf_pkg::Unity; wet_q <= abhsf_pkg::Unity;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				abhsf_pkg::REG_HI: hi_q <= cfg_data;
				abhsf_pkg::REG_TRI: tri_c_q <= cfg_data;
				abhsf_pkg::REG_AIR: air_q <= cfg_data;
				abhsf_pkg::REG_DAMP: damp_q <= cfg_data[15:0];
				abhsf_pkg::REG_GAIN: gain_q <= cfg_data[16:0];
				abhsf_pkg::REG_WET: wet_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// Filter state, held at working width.
	logic signed [W-1:0] tprev_q, tmid_q, x_q, corr_q, y_q;
	logic signed [W-1:0] tacc_q [3];
	logic signed [W-1:0] bprev_q [3], bev_q [3], bod_q [3];
	logic [1:0] phase_q;
	logic [1:0] flip_q;
	logic alt_q;

	state_t state_q;
	logic [4:0] step_q;
	logic [1:0] band_q; // band under work: 0 (band A) or 2 (hi)
	logic out_v_q;
	logic [SAMPLE_BITS-1:0] out_q;

	// Multiplier hookup.
	abhsf_pkg::mul_req_t req;
	logic signed [W-1:0] ma;
	logic signed [17:0] mb;
	logic mdone;
	logic signed [PB-1:0] mprod;

	abhsf_mul #(.ABits(W), .BBits(18)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(req), .a(ma), .b(mb),
		.done(mdone), .prod(mprod)
	);

	function automatic logic signed [W-1:0] asat(input logic signed [W-1:0] v);
		if (v > AMAX) return AMAX;
		if (v < AMIN) return AMIN;
		return v;
	endfunction

	function automatic logic signed [W-1:0] rsh8(input logic signed [W-1:0] v);
		return (v + W'(128)) >>> abhsf_pkg::CrossShift;
	endfunction

	logic [1:0] pp, pq;
	logic [1:0] bi;
	logic [1:0] tidx;
	logic bflip;
	logic signed [17:0] bcoef;
	logic signed [W-1:0] sel_acc;
	logic signed [W-1:0] pw;
	logic [16:0] gsat, wsat, dry;

	always_comb begin
		pp = (phase_q > 2'd2) ? 2'd0 : phase_q;
		pq = (pp == 2'd0) ? 2'd2 : pp - 2'd1;
		tidx = 2'(step_q - 5'd1);
		bi = alt_q ? 2'd0 : 2'd1;
		if (band_q == 2'd2) begin
			bi = 2'd2;
			bflip = alt_q;
			bcoef = hi_q;
		end else begin
			bflip = flip_q[bi[0] ? 1 : 0];
			bcoef = air_q;
		end
		sel_acc = bflip ? bev_q[bi] : bod_q[bi];
		gsat = (gain_q > abhsf_pkg::Unity) ? abhsf_pkg::Unity : gain_q;
		wsat = (wet_q > abhsf_pkg::Unity) ? abhsf_pkg::Unity : wet_q;
		dry = abhsf_pkg::Unity - wsat;
		pw = W'(mprod);
	end

	// Operand choice per step of the sequence.
	// Steps: 0 tri contrib, 1-3 tri damp, 4 band A contrib, 5 A odd, 6 A even,
	// 7 hi contrib, 8 hi odd, 9 hi even, 10 gain, 11 dry, 12 wet.
	logic signed [W-1:0] bodn;
	always_comb begin
		ma = '0; mb = '0; req.shift = 6'(abhsf_pkg::CoefFrac);
		bodn = bod_q[bi] - rsh8(bod_q[bi] - bev_q[bi]);
		unique case (step_q)
			5'd0: begin ma = tacc_q[pp]; mb = tri_c_q; end
			5'd1, 5'd2, 5'd3: begin
				ma = tacc_q[tidx]; mb = $signed({2'b00, damp_q});
				req.shift = 6'(abhsf_pkg::UnitFrac);
			end
			5'd4, 5'd7: begin ma = sel_acc; mb = bcoef; end
			5'd5, 5'd8: begin
				ma = bodn; mb = $signed({2'b00, damp_q}); req.shift = 6'(abhsf_pkg::UnitFrac);
			end
			5'd6, 5'd9: begin
				ma = bev_q[bi] - rsh8(bev_q[bi] - bod_q[bi]);
				mb = $signed({2'b00, damp_q}); req.shift = 6'(abhsf_pkg::UnitFrac);
			end
			5'd10: begin ma = y_q; mb = $signed({1'b0, gsat}); req.shift = 6'(abhsf_pkg::UnitFrac); end
			5'd11: begin ma = x_q; mb = $signed({1'b0, dry}); req.shift = 6'd0; end
			5'd12: begin ma = y_q; mb = $signed({1'b0, wsat}); req.shift = 6'd0; end
			default: ;
		endcase
		req.start = (state_q == ST_LOAD);
	end

	logic signed [W-1:0] dsum_q;
	logic in_ok;
	assign in_ok = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;

	// Sequencer: one product per step, accumulator add steps before the
	// triplet, band and hi contributions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; step_q <= '0; band_q <= '0;
			phase_q <= '0; flip_q <= '0; alt_q <= 1'b0; out_v_q <= 1'b0;
			tprev_q <= '0; tmid_q <= '0;
			x_q <= '0; corr_q <= '0; y_q <= '0; dsum_q <= '0;
			for (int i = 0; i < 3; i++) begin
				tacc_q[i] <= '0; bprev_q[i] <= '0; bev_q[i] <= '0; bod_q[i] <= '0;
			end
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ok) begin
					x_q <= W'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
					state_q <= ST_PRE;
					step_q <= '0;
					band_q <= 2'd0;
					corr_q <= '0;
					dsum_q <= '0;
				end
				ST_PRE: begin
					if (step_q == 5'd0) begin
						// Triplet add/subtract on the current and previous phase.
						tacc_q[pp] <= asat(tacc_q[pp] + tprev_q - x_q);
						tacc_q[pq] <= asat(tacc_q[pq] - (tprev_q - x_q));
					end else begin
						// Band add/subtract before its contribution.
						if (bflip) begin
							bev_q[bi] <= asat(bev_q[bi] + bprev_q[bi] - x_q);
							bod_q[bi] <= asat(bod_q[bi] - (bprev_q[bi] - x_q));
						end else begin
							bod_q[bi] <= asat(bod_q[bi] + bprev_q[bi] - x_q);
							bev_q[bi] <= asat(bev_q[bi] - (bprev_q[bi] - x_q));
						end
						bprev_q[bi] <= x_q;
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_MUL;
				ST_MUL: if (mdone) begin
					unique case (step_q)
						5'd0: begin corr_q <= corr_q + pw; tprev_q <= tmid_q; tmid_q <= x_q; end
						5'd1, 5'd2, 5'd3: tacc_q[tidx] <= asat(pw);
						5'd4, 5'd7: corr_q <= corr_q + pw;
						5'd5, 5'd8: bod_q[bi] <= asat(pw);
						5'd6, 5'd9: bev_q[bi] <= asat(pw);
						5'd10: y_q <= pw;
						5'd11: dsum_q <= pw;
						5'd12: dsum_q <= dsum_q + pw;
						default: ;
					endcase
					if (step_q == 5'd3) begin
						band_q <= 2'd0; step_q <= 5'd4; state_q <= ST_PRE;
					end else if (step_q == 5'd6) begin
						if (alt_q) flip_q[0] <= ~flip_q[0]; else flip_q[1] <= ~flip_q[1];
						band_q <= 2'd2; step_q <= 5'd7; state_q <= ST_PRE;
					end else if (step_q == 5'd9) begin
						y_q <= asat(x_q + corr_q);
						step_q <= 5'd10;
						state_q <= ST_LOAD;
					end else if (step_q == 5'd12) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 5'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					phase_q <= (pp == 2'd2) ? 2'd0 : pp + 2'd1;
					alt_q <= ~alt_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Final rounding and saturation of the mix.
	logic signed [W-1:0] mix;
	always_comb begin
		mix = (dsum_q + W'(32768)) >>> abhsf_pkg::UnitFrac;
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT)
			out_q <= SAMPLE_BITS'((mix > SMAX) ? SMAX : (mix < SMIN) ? SMIN : mix);
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = TW'(out_q);

	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != ST_IDLE, !s_axis_tready)
	`ASSERT_NEXT(a_out_after, clk, arst_n, state_q == ST_OUT, out_v_q)
	`ASSERT_IMPL(a_phase_ok, clk, arst_n, 1'b1, phase_q != 2'd3)
endmodule

### test/tb.sv
// Self-checking bench for the treble shelf filter: directed and random samples
// across many register settings. Depends on abhsf_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb;
	localparam longint LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0; // sample_in
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata; // sample_out
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;

	air_band_high_shelf_filter i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow registers and filter state of the predictor.
	longint m_hi, m_tri, m_air, m_damp, m_gain, m_wet;
	longint tp_prev, tp_mid;
	longint tp_acc[3];
	int tp_phase;
	longint bd_prev[3], bd_even[3], bd_odd[3];
	bit bd_flip[2];
	bit alt;

	logic [23:0] expected_samples[$];
	int errors = 0;
	int samples_sent = 0;
	int samples_checked = 0;
	int send_gap = 0;
	int recv_stall = 0;
	longint cycles = 0;

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint lim;
		lim = longint'(1) <<< (bits - 1);
		if (v > lim - 1)
			return lim - 1;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint band_update(int i, bit flip, longint x, longint coef);
		longint d, contrib;
		d = bd_prev[i] - x;
		if (flip) begin
			bd_even[i] = clip(bd_even[i] + d, abhsf_pkg::AccBits);
			bd_odd[i] = clip(bd_odd[i] - d, abhsf_pkg::AccBits);
			contrib = round_shift(bd_even[i] * coef, abhsf_pkg::CoefFrac);
		end else begin
			bd_odd[i] = clip(bd_odd[i] + d, abhsf_pkg::AccBits);
			bd_even[i] = clip(bd_even[i] - d, abhsf_pkg::AccBits);
			contrib = round_shift(bd_odd[i] * coef, abhsf_pkg::CoefFrac);
		end
		bd_odd[i] = clip(round_shift((bd_odd[i]
			- round_shift(bd_odd[i] - bd_even[i], abhsf_pkg::CrossShift)) * m_damp,
			abhsf_pkg::UnitFrac), abhsf_pkg::AccBits);
		bd_even[i] = clip(round_shift((bd_even[i]
			- round_shift(bd_even[i] - bd_odd[i], abhsf_pkg::CrossShift)) * m_damp,
			abhsf_pkg::UnitFrac), abhsf_pkg::AccBits);
		bd_prev[i] = x;
		return contrib;
	endfunction

	// Advances the filter state by one sample and returns the output sample.
	function automatic logic [23:0] shelf_filter_step(logic [23:0] raw);
		longint x, corr, d, y, gain, wet;
		int p, q;
		x = longint'($signed(raw));
		p = (tp_phase > 2) ? 0 : tp_phase;
		q = (p == 0) ? 2 : p - 1;
		d = tp_prev - x;
		tp_acc[p] = clip(tp_acc[p] + d, abhsf_pkg::AccBits);
		tp_acc[q] = clip(tp_acc[q] - d, abhsf_pkg::AccBits);
		corr = round_shift(tp_acc[p] * m_tri, abhsf_pkg::CoefFrac);
		tp_prev = tp_mid;
		tp_mid = x;
		for (int i = 0; i < 3; i++)
			tp_acc[i] = clip(round_shift(tp_acc[i] * m_damp, abhsf_pkg::UnitFrac),
				abhsf_pkg::AccBits);
		tp_phase = (p == 2) ? 0 : p + 1;
		if (alt) begin
			corr += band_update(0, bd_flip[0], x, m_air);
			bd_flip[0] = !bd_flip[0];
		end else begin
			corr += band_update(1, bd_flip[1], x, m_air);
			bd_flip[1] = !bd_flip[1];
		end
		corr += band_update(2, alt, x, m_hi);
		alt = !alt;
		y = clip(x + corr, abhsf_pkg::AccBits);
		gain = (m_gain > 65536) ? 65536 : m_gain;
		wet = (m_wet > 65536) ? 65536 : m_wet;
		y = round_shift(y * gain, abhsf_pkg::UnitFrac);
		y = round_shift(x * (65536 - wet) + y * wet, abhsf_pkg::UnitFrac);
		return 24'(clip(y, abhsf_pkg::SampleBits));
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what,
			$signed(got), $signed(want), $realtime);
	endtask

	// Sends one sample beat; a typed expectation replaces the predicted one.
	task automatic send_sample(logic [23:0] x, bit typed, logic [23:0] typed_out);
		logic [23:0] predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_gap) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = x;
		do @(posedge clk); while (!s_axis_tready);
		predicted = shelf_filter_step(x);
		expected_samples.push_back(typed ? typed_out : predicted);
		samples_sent++;
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			abhsf_pkg::REG_HI: m_hi = longint'($signed(value));
			abhsf_pkg::REG_TRI: m_tri = longint'($signed(value));
			abhsf_pkg::REG_AIR: m_air = longint'($signed(value));
			abhsf_pkg::REG_DAMP: m_damp = value[15:0];
			abhsf_pkg::REG_GAIN: m_gain = value[16:0];
			abhsf_pkg::REG_WET: m_wet = value[16:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(logic [17:0] hi, logic [17:0] tri_c, logic [17:0] air,
		logic [17:0] damp, logic [17:0] gain, logic [17:0] wet);
		write_reg(abhsf_pkg::REG_HI, hi);
		write_reg(abhsf_pkg::REG_TRI, tri_c);
		write_reg(abhsf_pkg::REG_AIR, air);
		write_reg(abhsf_pkg::REG_DAMP, damp);
		write_reg(abhsf_pkg::REG_GAIN, gain);
		write_reg(abhsf_pkg::REG_WET, wet);
	endtask

	// Receiver stall, changed at the falling edge.
	always @(negedge clk)
		m_axis_tready = !($urandom_range(99) < recv_stall);

	// Output checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata, '0);
			end else begin
				if (m_axis_tdata !== expected_samples[0])
					report_mismatch("sample_out", m_axis_tdata, expected_samples[0]);
				void'(expected_samples.pop_front());
				samples_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	typedef struct {
		logic [23:0] sample;
		bit typed;
	} directed_row_t;

	// With zero intensities, unity gain and full wet the output equals the input.
	directed_row_t directed[18] = '{
		'{24'h7fffff, 1}, '{24'h800000, 1}, '{24'h000000, 1}, '{24'hffffff, 1},
		'{24'h000001, 1}, '{24'h7fffff, 1}, '{24'h7fffff, 1}, '{24'h800000, 1},
		'{24'h800000, 1}, '{24'h555555, 1}, '{24'haaaaaa, 1}, '{24'h400000, 1},
		'{24'hc00000, 1}, '{24'h7fffff, 1}, '{24'h800000, 1}, '{24'h7fffff, 1},
		'{24'h123456, 1}, '{24'hedcba9, 1}
	};

	function automatic logic [23:0] pick_sample(int n, int style);
		case (style)
			0: return 24'($urandom());
			1: return n[0] ? 24'h7fffff : 24'h800000;
			2: return ($urandom_range(3) == 0) ? 24'h800000 : 24'h7fffff;
			default: return 24'($urandom_range(4095) - 2048);
		endcase
	endfunction

	initial begin
		int mode, style;
		m_hi = 0; m_tri = 0; m_air = 0; m_damp = 40960; m_gain = 65536; m_wet = 65536;
		tp_prev = 0; tp_mid = 0; tp_phase = 0; alt = 0;
		bd_flip[0] = 0; bd_flip[1] = 0;
		for (int i = 0; i < 3; i++) begin
			tp_acc[i] = 0; bd_prev[i] = 0; bd_even[i] = 0; bd_odd[i] = 0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed samples at the reset settings.
		foreach (directed[k])
			send_sample(directed[k].sample, directed[k].typed, directed[k].sample);
		drain_outputs();

		// Register phases: extremes, the special cases, then random settings.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: write_all(18'h20000, 18'h1ffff, 18'h20000, 18'd31207, 18'd0, 18'd65536);
				1: write_all(18'h1ffff, 18'h20000, 18'h1ffff, 18'd59578, 18'd131071,
					18'd32768);
				2: write_all(18'h1ffff, 18'h1ffff, 18'h1ffff, 18'd0, 18'd65536, 18'd131071);
				3: write_all(18'h1ffff, 18'h1ffff, 18'h1ffff, 18'd65535, 18'd65536,
					18'd65536);
				4: write_all(18'h20000, 18'h20000, 18'h20000, 18'd65535, 18'd70000, 18'd0);
				5: begin
					// Writes to unused indexes must change nothing.
					write_reg(abhsf_pkg::NumRegs, 18'($urandom()));
					write_reg(abhsf_pkg::NumRegs + 3'd1, 18'($urandom()));
					write_reg(abhsf_pkg::REG_GAIN, 18'd40000);
				end
				default: write_all(18'($urandom()), 18'($urandom()), 18'($urandom()),
					18'($urandom_range(59578, 31207)), 18'($urandom_range(65536)),
					18'($urandom_range(65536)));
			endcase
			if (ph >= 8)
				write_all(18'($urandom()), 18'($urandom()), 18'($urandom()),
					18'($urandom()), 18'($urandom()), 18'($urandom()));
			mode = ph % 4;
			send_gap = (mode == 1) ? 61 : (mode == 3) ? 12 : 0;
			recv_stall = (mode == 2) ? 61 : (mode == 3) ? 12 : 0;
			style = (ph == 3 || ph == 4) ? 1 : 0;
			for (int n = 0; n < 52; n++)
				send_sample(pick_sample(n, (n % 9 == 8) ? $urandom_range(3) : style), 0, '0);
			drain_outputs();
		end

		$display("Sent %0d samples and checked %0d outputs over twelve register phases,",
			samples_sent, samples_checked);
		$display("covering extreme intensities, zero and full damping and idle patterns.");
		if (errors == 0 && expected_samples.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/abhsf_pkg.sv
rtl/core/abhsf_mul.sv
rtl/core/air_band_high_shelf_filter.sv
test/tb.sv
